/* hw/rtl/mrtu_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame receiver.
package mrtu_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CRC_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned USER_W   = 1 + STATUS_W;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

	localparam logic [BYTE_W-1:0] SLAVE_ADDR_RST = 8'd1;

	localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd2;

	typedef enum logic [5:0] {
		PH_HUNT   = 6'b000001,
		PH_FUNC   = 6'b000010,
		PH_COUNT  = 6'b000100,
		PH_DATA   = 6'b001000,
		PH_CRC_LO = 6'b010000,
		PH_CRC_HI = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                in_frame;
		logic                frame_end;
		logic [STATUS_W-1:0] frame_status;
	} result_t;

	// reflected CRC-16, one byte, bit-serial steps unrolled
	function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] c,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] v;
		v = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[0]) begin
				v = (v >> 1) ^ CRC_POLY;
			end else begin
				v = v >> 1;
			end
		end
		return v;
	endfunction

endpackage

/* hw/rtl/mrtu_decoder.sv */
// Frame phase tracking, running CRC and result decode, one byte per step.
module mrtu_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [mrtu_pkg::BYTE_W-1:0]    byte_in,
	input  logic [mrtu_pkg::BYTE_W-1:0]    slave_address,
	output mrtu_pkg::result_t              res
);

	mrtu_pkg::phase_t                  phase_q, phase_d;
	logic [mrtu_pkg::CRC_W-1:0]        crc_q, crc_d;
	logic [mrtu_pkg::BYTE_W-1:0]       left_q, left_d;
	logic [mrtu_pkg::BYTE_W-1:0]       crc_lo_q, crc_lo_d;
	logic [mrtu_pkg::BYTE_W-1:0]       left_dec;
	logic [mrtu_pkg::CRC_W-1:0]        crc_upd;
	logic [mrtu_pkg::CRC_W-1:0]        crc_got;

	assign left_dec = left_q - 8'd1;
	assign crc_got  = {byte_in, crc_lo_q};
	// hunt restarts from the initial value
	assign crc_upd  = mrtu_pkg::crc_add_byte(
		(phase_q == mrtu_pkg::PH_FUNC || phase_q == mrtu_pkg::PH_COUNT ||
		 phase_q == mrtu_pkg::PH_DATA) ? crc_q : mrtu_pkg::CRC_INIT, byte_in);

	always_comb begin
		phase_d              = phase_q;
		crc_d                = crc_q;
		left_d               = left_q;
		crc_lo_d             = crc_lo_q;
		res.out_byte         = byte_in;
		res.in_frame         = 1'b1;
		res.frame_end        = 1'b0;
		res.frame_status     = mrtu_pkg::STATUS_NONE;
		case (phase_q)
			mrtu_pkg::PH_FUNC: begin
				crc_d   = crc_upd;
				phase_d = mrtu_pkg::PH_COUNT;
			end
			mrtu_pkg::PH_COUNT: begin
				crc_d   = crc_upd;
				left_d  = byte_in;
				phase_d = (byte_in == '0) ? mrtu_pkg::PH_CRC_LO : mrtu_pkg::PH_DATA;
			end
			mrtu_pkg::PH_DATA: begin
				crc_d  = crc_upd;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = mrtu_pkg::PH_CRC_LO;
				end
			end
			mrtu_pkg::PH_CRC_LO: begin
				crc_lo_d = byte_in;
				phase_d  = mrtu_pkg::PH_CRC_HI;
			end
			mrtu_pkg::PH_CRC_HI: begin
				res.frame_end    = 1'b1;
				res.frame_status = (crc_got == crc_q) ? mrtu_pkg::STATUS_OK
					: mrtu_pkg::STATUS_CRC_ERR;
				crc_d   = mrtu_pkg::CRC_INIT;
				left_d  = '0;
				phase_d = mrtu_pkg::PH_HUNT;
			end
			default: begin
				if (byte_in == slave_address) begin
					crc_d   = crc_upd;
					phase_d = mrtu_pkg::PH_FUNC;
				end else begin
					res.in_frame = 1'b0;
					phase_d      = mrtu_pkg::PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mrtu_pkg::PH_HUNT;
			crc_q    <= mrtu_pkg::CRC_INIT;
			left_q   <= '0;
			crc_lo_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			left_q   <= left_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

/* hw/rtl/modbus_rtu_frame_receiver.sv */
// Top level of the Modbus RTU frame receiver: input register, decoder, output register.
//
// Bytes from the serial line arrive on the s_axis channel, one transfer per byte
// (tdata = received byte). Every byte gives exactly one transfer on m_axis:
// tdata echoes the byte, tlast marks the second CRC byte of a frame, and tuser
// carries in_frame (bit 0) and frame_status (bits 2:1: 0 none, 1 ok, 2 CRC error).
// The receiver hunts for a byte equal to slave_address, then takes function,
// count N, N data bytes and the CRC (low byte first), checking a CRC-16 over all
// but the CRC bytes.
// slave_address is written through cfg_we/cfg_wdata; a write applies from the next
// hunt and should only be made with the block idle.
// Output valid rises once a byte has passed the input register and then the result
// register; throughput is one byte per cycle while m_axis accepts, set by the
// combinational unrolled CRC byte update.
// Reset clears both stages, returns to hunting and sets slave_address to 1.
// When the m_axis side stalls, the full result register holds and s_axis_tready
// drops once the input register is also full; no byte is lost or repeated.
module modbus_rtu_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [mrtu_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] rx_byte
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [mrtu_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] out_byte
	output logic                          m_axis_tlast,   // frame_end
	output logic [mrtu_pkg::USER_W-1:0]   m_axis_tuser,   // [0] in_frame, [2:1] frame_status
	input  logic                          cfg_we,
	input  logic [mrtu_pkg::BYTE_W-1:0]   cfg_wdata
);

	logic [mrtu_pkg::BYTE_W-1:0] slave_addr_q;
	logic                        valid_s1;
	logic [mrtu_pkg::BYTE_W-1:0] byte_s1;
	logic                        valid_s2;
	mrtu_pkg::result_t           res_s2;
	mrtu_pkg::result_t           res_comb;
	logic                        advance;

	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= mrtu_pkg::SLAVE_ADDR_RST;
		end else if (cfg_we) begin
			slave_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	mrtu_decoder u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1 && advance),
		.byte_in       (byte_s1),
		.slave_address (slave_addr_q),
		.res           (res_comb)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2.out_byte;
	assign m_axis_tlast  = res_s2.frame_end;
	assign m_axis_tuser  = {res_s2.frame_status, res_s2.in_frame};

	a_end_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
		else $error("frame end outside a frame");

	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:1] != mrtu_pkg::STATUS_NONE)))
		else $error("frame status without frame end");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2:1] == mrtu_pkg::STATUS_NONE ||
			m_axis_tuser[2:1] == mrtu_pkg::STATUS_OK ||
			m_axis_tuser[2:1] == mrtu_pkg::STATUS_CRC_ERR))
		else $error("unused frame status code");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output back-pressure");

endmodule

/* sim/modbus_rtu_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU frame receiver: CRC frames, hunting, stalls.
module modbus_rtu_frame_receiver_tb;

	localparam int unsigned RANDOM_BYTES = 1020;
	localparam int unsigned HOLD_CYCLES  = 300;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [mrtu_pkg::BYTE_W-1:0]   s_axis_tdata  = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [mrtu_pkg::BYTE_W-1:0]   m_axis_tdata;
	logic                          m_axis_tlast;
	logic [mrtu_pkg::USER_W-1:0]   m_axis_tuser;
	logic                          cfg_we        = 1'b0;
	logic [mrtu_pkg::BYTE_W-1:0]   cfg_wdata     = '0;

	// local copy of the receiver state
	mrtu_pkg::phase_t              link_phase  = mrtu_pkg::PH_HUNT;
	logic [mrtu_pkg::CRC_W-1:0]    frame_crc   = mrtu_pkg::CRC_INIT;
	logic [mrtu_pkg::BYTE_W-1:0]   data_left   = '0;
	logic [mrtu_pkg::BYTE_W-1:0]   crc_lo_seen = '0;
	logic [mrtu_pkg::BYTE_W-1:0]   own_addr    = mrtu_pkg::SLAVE_ADDR_RST;

	mrtu_pkg::result_t             echo_q[$];
	int unsigned                   errors      = 0;
	int unsigned                   frame_bytes = 0;
	bit                            src_gaps    = 1'b1;
	bit                            sink_gaps   = 1'b1;
	int unsigned                   hold_reqs   = 0;
	int unsigned                   hold_taken  = 0;
	int unsigned                   hold_left   = 0;

	modbus_rtu_frame_receiver u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [mrtu_pkg::CRC_W-1:0] crc16_fold(
		input logic [mrtu_pkg::CRC_W-1:0] acc, input logic [mrtu_pkg::BYTE_W-1:0] d);
		logic [mrtu_pkg::CRC_W-1:0] r;
		r = acc ^ {8'h00, d};
		repeat (8) r = r[0] ? ({1'b0, r[mrtu_pkg::CRC_W-1:1]} ^ mrtu_pkg::CRC_POLY)
			: {1'b0, r[mrtu_pkg::CRC_W-1:1]};
		return r;
	endfunction

	function automatic mrtu_pkg::result_t track_byte(input logic [mrtu_pkg::BYTE_W-1:0] b);
		mrtu_pkg::result_t          r;
		logic [mrtu_pkg::CRC_W-1:0] got;
		r.out_byte     = b;
		r.in_frame     = 1'b1;
		r.frame_end    = 1'b0;
		r.frame_status = mrtu_pkg::STATUS_NONE;
		case (link_phase)
			mrtu_pkg::PH_FUNC: begin
				frame_crc  = crc16_fold(frame_crc, b);
				link_phase = mrtu_pkg::PH_COUNT;
			end
			mrtu_pkg::PH_COUNT: begin
				frame_crc  = crc16_fold(frame_crc, b);
				data_left  = b;
				link_phase = (b == 8'd0) ? mrtu_pkg::PH_CRC_LO : mrtu_pkg::PH_DATA;
			end
			mrtu_pkg::PH_DATA: begin
				frame_crc = crc16_fold(frame_crc, b);
				data_left = data_left - 8'd1;
				if (data_left == 8'd0) begin
					link_phase = mrtu_pkg::PH_CRC_LO;
				end
			end
			mrtu_pkg::PH_CRC_LO: begin
				crc_lo_seen = b;
				link_phase  = mrtu_pkg::PH_CRC_HI;
			end
			mrtu_pkg::PH_CRC_HI: begin
				got            = {b, crc_lo_seen};
				r.frame_end    = 1'b1;
				r.frame_status = (got == frame_crc) ? mrtu_pkg::STATUS_OK
					: mrtu_pkg::STATUS_CRC_ERR;
				frame_crc      = mrtu_pkg::CRC_INIT;
				data_left      = '0;
				link_phase     = mrtu_pkg::PH_HUNT;
			end
			default: begin
				if (b == own_addr) begin
					frame_crc  = crc16_fold(mrtu_pkg::CRC_INIT, b);
					link_phase = mrtu_pkg::PH_FUNC;
				end else begin
					r.in_frame = 1'b0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	task automatic send_byte(input logic [mrtu_pkg::BYTE_W-1:0] b);
		mrtu_pkg::result_t r;
		@(negedge clk);
		if (src_gaps) begin
			while ($urandom_range(99) < 8) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		r = track_byte(b);
		if (r.in_frame) begin
			frame_bytes++;
		end
		echo_q.insert(echo_q.size(), r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (echo_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_address(input logic [mrtu_pkg::BYTE_W-1:0] a);
		wait_drained();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= a;
		own_addr  = a;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// fill: 0 random, 1 all zero, 2 all ones
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
		input logic [7:0] count, input int unsigned fill, input bit spoil);
		logic [7:0]  bytes_q[$];
		logic [15:0] c;
		bytes_q = {addr, func, count};
		for (int k = 0; k < count; k++) begin
			bytes_q.insert(bytes_q.size(),
				fill == 1 ? 8'h00 : fill == 2 ? 8'hFF : 8'($urandom_range(255)));
		end
		c = mrtu_pkg::CRC_INIT;
		foreach (bytes_q[k]) c = crc16_fold(c, bytes_q[k]);
		if (spoil) begin
			c = c ^ (16'd1 << $urandom_range(15));
		end
		bytes_q.insert(bytes_q.size(), c[7:0]);
		bytes_q.insert(bytes_q.size(), c[15:8]);
		foreach (bytes_q[k]) send_byte(bytes_q[k]);
	endtask

	task automatic send_noise(input int unsigned n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom_range(255));
			send_byte(b == own_addr ? ~b : b);
		end
	endtask

	task automatic resync();
		while (link_phase != mrtu_pkg::PH_HUNT) send_byte(8'($urandom_range(255)));
	endtask

	task automatic test_default_address();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(mrtu_pkg::SLAVE_ADDR_RST, 8'h00, 8'd0, 0, 1'b0);
	endtask

	task automatic test_address_extremes();
		set_address(8'hFF);
		send_frame(8'hFF, 8'hFF, 8'd1, 2, 1'b0);
		set_address(8'h00);
		send_frame(8'h00, 8'h55, 8'd0, 1, 1'b1);
	endtask

	task automatic test_address_change_mid_frame();
		logic [15:0] c;
		send_byte(own_addr);
		send_byte(8'h03);
		send_byte(8'h00);
		c = frame_crc;
		set_address(8'hA5);
		send_byte(c[7:0]);
		send_byte(c[15:8]);
		send_byte(8'h00);
		send_frame(8'hA5, 8'h10, 8'd2, 0, 1'b0);
	endtask

	task automatic test_backpressure();
		src_gaps = 1'b0;
		hold_reqs++;
		repeat (3) send_frame(own_addr, 8'h04, 8'd8, 0, 1'b0);
		wait_drained();
		src_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		int unsigned pick;
		logic [7:0]  count;
		frame_bytes = 0;
		while (frame_bytes < RANDOM_BYTES) begin
			src_gaps  = !(frame_bytes >= 400 && frame_bytes < 600);
			sink_gaps = src_gaps;
			if ($urandom_range(99) < 4) begin
				pick = $urandom_range(3);
				set_address(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom_range(255)));
			end
			count = ($urandom_range(99) < 3) ? 8'($urandom_range(9, 255)) : 8'($urandom_range(8));
			pick  = $urandom_range(99);
			if (pick < 70) begin
				send_frame(own_addr, 8'($urandom_range(255)), count, 0, 1'b0);
			end else if (pick < 85) begin
				send_frame(own_addr, 8'($urandom_range(255)), count, 0, 1'b1);
			end else if (pick < 93) begin
				send_byte(own_addr);
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(1, 8)));
				resync();
			end else if (pick < 97) begin
				send_frame(8'(own_addr + 8'($urandom_range(1, 255))), 8'($urandom_range(255)),
					count, 0, 1'b0);
				resync();
			end else begin
				send_noise($urandom_range(1, 6));
			end
		end
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_reqs != hold_taken) begin
			hold_taken    <= hold_reqs;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(sink_gaps && $urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin : check_echo
		mrtu_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (echo_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected transfer, expected none, got byte %0h last %b user %b",
					$time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
			end else begin
				want = echo_q.pop_front();
				check_field("out_byte", want.out_byte, m_axis_tdata);
				check_field("in_frame", 8'(want.in_frame), 8'(m_axis_tuser[0]));
				check_field("frame_end", 8'(want.frame_end), 8'(m_axis_tlast));
				check_field("frame_status", 8'(want.frame_status), 8'(m_axis_tuser[2:1]));
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_default_address();
		test_address_extremes();
		test_address_change_mid_frame();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
